[rtl/thermal_fault_and_derating_macros.svh]
// Assertion macros for the thermal fault and derating block.
`ifndef THERMAL_FAULT_AND_DERATING_MACROS_SVH
`define THERMAL_FAULT_AND_DERATING_MACROS_SVH

`ifndef ASSERT_OFF
// Condition must hold in the same cycle as the trigger.
`define TFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfd assertion failed");
// Condition must hold in the cycle after the trigger.
`define TFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfd assertion failed");
`else
`define TFD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/tfd_pkg.sv]
`default_nettype none

package tfd_pkg;

   localparam int TEMP_W      = 16;
   localparam int CFG_TEMP_W  = 13;
   localparam int VALUE_W     = 16;
   localparam int FRAC_W      = 8;
   localparam int LIMIT_W     = VALUE_W + FRAC_W;
   localparam int PERIOD_W    = 24;
   localparam int PERSIST_W   = 16;
   localparam int RATIO_W     = 8;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 24;

   // Parameter defaults.
   localparam int unsigned FAULT_PERSIST_TICKS_DEF = 10;
   localparam int unsigned DOWN_RATIO_Q8_DEF       = 26;
   localparam int unsigned UP_RATIO_Q8_DEF         = 26;
   localparam int unsigned FAULT_HYSTERESIS_DEF    = 50;

   // Register reset values.
   localparam logic signed [CFG_TEMP_W-1:0] OVER_TEMP_LIMIT_RST = 13'sd1000;
   localparam logic signed [CFG_TEMP_W-1:0] DERATE_ON_TEMP_RST  = 13'sd850;
   localparam logic signed [CFG_TEMP_W-1:0] DERATE_OFF_TEMP_RST = 13'sd750;
   localparam logic [PERIOD_W-1:0]          DERATE_PERIOD_RST   = 24'd9000;
   localparam logic [VALUE_W-1:0]           RATED_CURRENT_RST   = 16'd1000;
   localparam logic [VALUE_W-1:0]           RATED_VOLTAGE_RST   = 16'd7500;
   localparam logic [VALUE_W-1:0]           CURRENT_FLOOR_RST   = 16'd100;
   localparam logic [VALUE_W-1:0]           VOLTAGE_FLOOR_RST   = 16'd2000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OVER_TEMP_LIMIT     = 4'd0,
      CSR_DERATE_ON_TEMP      = 4'd1,
      CSR_DERATE_OFF_TEMP     = 4'd2,
      CSR_DERATE_PERIOD_TICKS = 4'd3,
      CSR_RATED_CURRENT       = 4'd4,
      CSR_RATED_VOLTAGE       = 4'd5,
      CSR_CURRENT_FLOOR       = 4'd6,
      CSR_VOLTAGE_FLOOR       = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp_first;
      logic signed [TEMP_W-1:0] temp_second;
      logic [VALUE_W-1:0]       current_avg;
      logic [VALUE_W-1:0]       voltage_avg;
   } req_type;

   typedef struct packed {
      logic               over_temp_fault;
      logic               fault_event;
      logic [VALUE_W-1:0] current_limit;
      logic [VALUE_W-1:0] voltage_limit;
   } rsp_type;

   // Settings shared by both derating channels.
   typedef struct packed {
      logic signed [CFG_TEMP_W-1:0] on_temp;
      logic signed [CFG_TEMP_W-1:0] off_temp;
      logic [PERIOD_W-1:0]          period;
   } derate_cfg_type;

   // Settings of one derating channel.
   typedef struct packed {
      logic [VALUE_W-1:0] rated;
      logic [VALUE_W-1:0] floor_value;
   } chan_cfg_type;

   typedef struct packed {
      logic fault;
      logic fault_event;
   } fault_status_type;

endpackage

`default_nettype wire

[rtl/tfd_fault.sv]
`default_nettype none

// Latched over-temperature fault with an up/down persistence counter.
module tfd_fault #(
   parameter int unsigned FAULT_PERSIST_TICKS = tfd_pkg::FAULT_PERSIST_TICKS_DEF,
   parameter int unsigned FAULT_HYSTERESIS    = tfd_pkg::FAULT_HYSTERESIS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   enable,
   input  wire logic signed [tfd_pkg::TEMP_W-1:0]      temp_hot,
   input  wire logic signed [tfd_pkg::CFG_TEMP_W-1:0]  over_temp_limit,
   output tfd_pkg::fault_status_type                   status_next
);

   localparam int LEVEL_W = tfd_pkg::TEMP_W + 2;

   logic                              fault_ff;
   logic                              fault_in;
   logic [tfd_pkg::PERSIST_W-1:0]     count_ff;
   logic [tfd_pkg::PERSIST_W-1:0]     count_in;
   logic [tfd_pkg::PERSIST_W-1:0]     count_inc;
   logic signed [LEVEL_W-1:0]         clear_level;
   logic                              cond;
   logic                              event_flag;

   always_comb begin
      clear_level = {{(LEVEL_W - tfd_pkg::CFG_TEMP_W){over_temp_limit[tfd_pkg::CFG_TEMP_W-1]}},
                     over_temp_limit} - LEVEL_W'(FAULT_HYSTERESIS);
      cond        = fault_ff ? (temp_hot < clear_level) : (temp_hot > over_temp_limit);
      count_inc   = count_ff + 1'b1;
      fault_in    = fault_ff;
      count_in    = count_ff;
      event_flag  = 1'b0;
      if (cond) begin
         count_in = count_inc;
         if (count_inc >= tfd_pkg::PERSIST_W'(FAULT_PERSIST_TICKS)) begin
            count_in   = '0;
            event_flag = !fault_ff;
            fault_in   = !fault_ff;
         end
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
      end
      status_next.fault       = fault_in;
      status_next.fault_event = event_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff <= 1'b0;
         count_ff <= '0;
      end else if (enable) begin
         fault_ff <= fault_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/tfd_derate_chan.sv]
`default_nettype none

// One derating channel: steps its limit down while hot and back up once cool.
module tfd_derate_chan #(
   parameter int unsigned              DOWN_RATIO_Q8 = tfd_pkg::DOWN_RATIO_Q8_DEF,
   parameter int unsigned              UP_RATIO_Q8   = tfd_pkg::UP_RATIO_Q8_DEF,
   parameter logic [tfd_pkg::VALUE_W-1:0] RATED_RESET = tfd_pkg::RATED_CURRENT_RST
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               enable,
   input  wire logic signed [tfd_pkg::TEMP_W-1:0]  temp_hot,
   input  wire logic [tfd_pkg::VALUE_W-1:0]        avg,
   input  wire tfd_pkg::derate_cfg_type            derate_cfg,
   input  wire tfd_pkg::chan_cfg_type              chan_cfg,
   output logic [tfd_pkg::VALUE_W-1:0]             limit_next
);

   localparam int LW = tfd_pkg::LIMIT_W;
   localparam int PW = tfd_pkg::PERIOD_W;
   localparam logic [tfd_pkg::FRAC_W-1:0] FRAC_ZERO = '0;

   logic                            active_ff, active_in;
   logic                            captured_ff, captured_in;
   logic [PW-1:0]                   period_ff, period_in;
   logic [LW-1:0]                   limit_ff, limit_in;
   logic [tfd_pkg::VALUE_W-1:0]     ref_ff, ref_in;
   logic [LW-1:0]                   step_ff, step_in;
   logic [PW-1:0]                   period_eff;
   logic [PW-1:0]                   period_inc;
   logic [LW-1:0]                   lim_work;
   logic [LW-1:0]                   step_work;
   logic [LW-1:0]                   floor_fix;
   logic [LW-1:0]                   rated_fix;

   always_comb begin
      period_eff  = (derate_cfg.period == '0) ? PW'(1) : derate_cfg.period;
      period_inc  = period_ff + 1'b1;
      floor_fix   = {chan_cfg.floor_value, FRAC_ZERO};
      rated_fix   = {chan_cfg.rated, FRAC_ZERO};
      active_in   = active_ff;
      captured_in = captured_ff;
      period_in   = period_ff;
      limit_in    = limit_ff;
      ref_in      = ref_ff;
      step_in     = step_ff;
      lim_work    = limit_ff;
      step_work   = step_ff;
      if (active_ff && (period_inc < period_eff)) begin
         period_in = period_inc;
      end else begin
         period_in = '0;
         if (temp_hot >= derate_cfg.on_temp) begin
            active_in = 1'b1;
            if (!captured_ff) begin
               // Capture the present value; the step is a fixed fraction of it.
               ref_in      = avg;
               step_work   = LW'(avg) * LW'(DOWN_RATIO_Q8);
               lim_work    = {avg, FRAC_ZERO};
               captured_in = 1'b1;
            end
            step_in = step_work;
            if ({1'b0, lim_work} > ({1'b0, floor_fix} + {1'b0, step_work})) begin
               limit_in = lim_work - step_work;
            end else begin
               limit_in = floor_fix;
            end
         end else if ((temp_hot < derate_cfg.off_temp) && active_ff) begin
            if (captured_ff) begin
               step_work   = LW'(ref_ff) * LW'(UP_RATIO_Q8);
               captured_in = 1'b0;
            end
            step_in = step_work;
            if (({1'b0, limit_ff} + {1'b0, step_work}) < {1'b0, rated_fix}) begin
               limit_in = limit_ff + step_work;
            end else begin
               limit_in  = rated_fix;
               active_in = 1'b0;
            end
         end
      end
      limit_next = limit_in[LW-1:tfd_pkg::FRAC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         captured_ff <= 1'b0;
         period_ff   <= '0;
         limit_ff    <= {RATED_RESET, FRAC_ZERO};
         ref_ff      <= '0;
         step_ff     <= '0;
      end else if (enable) begin
         active_ff   <= active_in;
         captured_ff <= captured_in;
         period_ff   <= period_in;
         limit_ff    <= limit_in;
         ref_ff      <= ref_in;
         step_ff     <= step_in;
      end
   end

endmodule

`default_nettype wire

[rtl/thermal_fault_and_derating.sv]
// Over-temperature protection with current and voltage derating.
// One transfer on the req_ channel is one protection tick: two signed temperature
// samples and the averaged current and voltage. For every tick the block returns
// exactly one transfer on the rsp_ channel with the latched fault, a one-tick fault
// event and the present current and voltage limits (integer part, 0.1 units).
// rsp_valid rises at the edge that runs the update pass, after the req_ transfer
// has been held in the input register. A new tick is taken in every cycle while
// rsp_ready is high, set by the single update pass from the input register into
// the state and result registers.
// When the receiver holds rsp_ready low, the result register keeps its transfer and
// one further tick waits in the input register; req_ready then falls until the
// result is taken. Nothing is dropped.
// Settings are written on the csr_ channel, which is always ready; an index beyond
// the last register is ignored. Write it only while no tick is in flight.
// Synchronous reset restores all register defaults, clears the fault and both
// derating channels and sets each limit to its rated default.
`default_nettype none

`include "thermal_fault_and_derating_macros.svh"

module thermal_fault_and_derating #(
   parameter int unsigned FAULT_PERSIST_TICKS = tfd_pkg::FAULT_PERSIST_TICKS_DEF,
   parameter int unsigned DOWN_RATIO_Q8       = tfd_pkg::DOWN_RATIO_Q8_DEF,
   parameter int unsigned UP_RATIO_Q8         = tfd_pkg::UP_RATIO_Q8_DEF,
   parameter int unsigned FAULT_HYSTERESIS    = tfd_pkg::FAULT_HYSTERESIS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire tfd_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output tfd_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [tfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [tfd_pkg::CSR_DATA_W-1:0]     csr_data
);

   // Configuration registers.
   logic signed [tfd_pkg::CFG_TEMP_W-1:0] over_temp_limit_ff;
   logic signed [tfd_pkg::CFG_TEMP_W-1:0] derate_on_temp_ff;
   logic signed [tfd_pkg::CFG_TEMP_W-1:0] derate_off_temp_ff;
   logic [tfd_pkg::PERIOD_W-1:0]          derate_period_ff;
   logic [tfd_pkg::VALUE_W-1:0]           rated_current_ff;
   logic [tfd_pkg::VALUE_W-1:0]           rated_voltage_ff;
   logic [tfd_pkg::VALUE_W-1:0]           current_floor_ff;
   logic [tfd_pkg::VALUE_W-1:0]           voltage_floor_ff;

   // Input register and result register.
   logic                                  req_valid_ff, req_valid_in;
   tfd_pkg::req_type                      req_data_ff;
   logic                                  rsp_valid_ff, rsp_valid_in;
   tfd_pkg::rsp_type                      rsp_data_ff, rsp_data_in;

   logic                                  advance;
   logic signed [tfd_pkg::TEMP_W-1:0]     temp_hot;
   tfd_pkg::derate_cfg_type               derate_cfg;
   tfd_pkg::chan_cfg_type                 current_cfg;
   tfd_pkg::chan_cfg_type                 voltage_cfg;
   tfd_pkg::fault_status_type             fault_next;
   logic [tfd_pkg::VALUE_W-1:0]           current_limit_next;
   logic [tfd_pkg::VALUE_W-1:0]           voltage_limit_next;

   // The held tick is processed whenever the result register is free or is
   // being emptied in this cycle; the state registers update on the same edge.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (req_valid && req_ready) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Configuration writes: data is cut to the width of the register.
   always_ff @(posedge clock) begin
      if (reset) begin
         over_temp_limit_ff <= tfd_pkg::OVER_TEMP_LIMIT_RST;
         derate_on_temp_ff  <= tfd_pkg::DERATE_ON_TEMP_RST;
         derate_off_temp_ff <= tfd_pkg::DERATE_OFF_TEMP_RST;
         derate_period_ff   <= tfd_pkg::DERATE_PERIOD_RST;
         rated_current_ff   <= tfd_pkg::RATED_CURRENT_RST;
         rated_voltage_ff   <= tfd_pkg::RATED_VOLTAGE_RST;
         current_floor_ff   <= tfd_pkg::CURRENT_FLOOR_RST;
         voltage_floor_ff   <= tfd_pkg::VOLTAGE_FLOOR_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tfd_pkg::CSR_OVER_TEMP_LIMIT: begin
               over_temp_limit_ff <= csr_data[tfd_pkg::CFG_TEMP_W-1:0];
            end
            tfd_pkg::CSR_DERATE_ON_TEMP: begin
               derate_on_temp_ff <= csr_data[tfd_pkg::CFG_TEMP_W-1:0];
            end
            tfd_pkg::CSR_DERATE_OFF_TEMP: begin
               derate_off_temp_ff <= csr_data[tfd_pkg::CFG_TEMP_W-1:0];
            end
            tfd_pkg::CSR_DERATE_PERIOD_TICKS: begin
               derate_period_ff <= csr_data[tfd_pkg::PERIOD_W-1:0];
            end
            tfd_pkg::CSR_RATED_CURRENT: begin
               rated_current_ff <= csr_data[tfd_pkg::VALUE_W-1:0];
            end
            tfd_pkg::CSR_RATED_VOLTAGE: begin
               rated_voltage_ff <= csr_data[tfd_pkg::VALUE_W-1:0];
            end
            tfd_pkg::CSR_CURRENT_FLOOR: begin
               current_floor_ff <= csr_data[tfd_pkg::VALUE_W-1:0];
            end
            tfd_pkg::CSR_VOLTAGE_FLOOR: begin
               voltage_floor_ff <= csr_data[tfd_pkg::VALUE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The hotter of the two samples drives both the fault and the derating.
   always_comb begin
      temp_hot = (req_data_ff.temp_first < req_data_ff.temp_second) ?
                 req_data_ff.temp_second : req_data_ff.temp_first;
      derate_cfg.on_temp      = derate_on_temp_ff;
      derate_cfg.off_temp     = derate_off_temp_ff;
      derate_cfg.period       = derate_period_ff;
      current_cfg.rated       = rated_current_ff;
      current_cfg.floor_value = current_floor_ff;
      voltage_cfg.rated       = rated_voltage_ff;
      voltage_cfg.floor_value = voltage_floor_ff;
   end

   tfd_fault #(
      .FAULT_PERSIST_TICKS (FAULT_PERSIST_TICKS),
      .FAULT_HYSTERESIS    (FAULT_HYSTERESIS)
   ) u_fault (
      .clock           (clock),
      .reset           (reset),
      .enable          (advance),
      .temp_hot        (temp_hot),
      .over_temp_limit (over_temp_limit_ff),
      .status_next     (fault_next)
   );

   tfd_derate_chan #(
      .DOWN_RATIO_Q8 (DOWN_RATIO_Q8),
      .UP_RATIO_Q8   (UP_RATIO_Q8),
      .RATED_RESET   (tfd_pkg::RATED_CURRENT_RST)
   ) u_current_chan (
      .clock      (clock),
      .reset      (reset),
      .enable     (advance),
      .temp_hot   (temp_hot),
      .avg        (req_data_ff.current_avg),
      .derate_cfg (derate_cfg),
      .chan_cfg   (current_cfg),
      .limit_next (current_limit_next)
   );

   tfd_derate_chan #(
      .DOWN_RATIO_Q8 (DOWN_RATIO_Q8),
      .UP_RATIO_Q8   (UP_RATIO_Q8),
      .RATED_RESET   (tfd_pkg::RATED_VOLTAGE_RST)
   ) u_voltage_chan (
      .clock      (clock),
      .reset      (reset),
      .enable     (advance),
      .temp_hot   (temp_hot),
      .avg        (req_data_ff.voltage_avg),
      .derate_cfg (derate_cfg),
      .chan_cfg   (voltage_cfg),
      .limit_next (voltage_limit_next)
   );

   always_comb begin
      rsp_data_in.over_temp_fault = fault_next.fault;
      rsp_data_in.fault_event     = fault_next.fault_event;
      rsp_data_in.current_limit   = current_limit_next;
      rsp_data_in.voltage_limit   = voltage_limit_next;
   end

   // A fault event is only ever reported together with the fault itself.
   `TFD_ASSERT_IMPLY(a_event_has_fault, clock, reset, rsp_valid_ff && rsp_data_ff.fault_event, rsp_data_ff.over_temp_fault)
   // With both registers full and the receiver stalled, no new tick is taken.
   `TFD_ASSERT_IMPLY(a_blocked_no_take, clock, reset, req_valid_ff && rsp_valid_ff && !rsp_ready, !req_ready)
   // A fault that trips in the update pass reaches the result register.
   `TFD_ASSERT_NEXT(a_event_delivered, clock, reset, advance && fault_next.fault_event, rsp_valid_ff && rsp_data_ff.fault_event)

endmodule

`default_nettype wire
